// File: hdl/i2cms_pkg.sv
// Shared types, op codes and helpers for the I2C master line sequencer.
// No dependencies; imported by every module of the block.
package i2cms_pkg;

   // Item kinds on the request channel; the same codes name the running op
   localparam logic [2:0] OP_IDLE  = 3'd0;  // as a kind: tick
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_STOP  = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;
   localparam logic [2:0] OP_SACK  = 3'd5;
   localparam logic [2:0] OP_MACK  = 3'd6;
   localparam logic [2:0] OP_TICK2 = 3'd7;  // unused kind, treated as tick

   localparam logic [15:0] PHASE_TICKS_RST = 16'd5;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] tx_byte;
      logic       master_nack;
      logic       sda_in;
   } i2cms_req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       slave_nack;
      logic       rejected;
   } i2cms_rsp_type;

   // Classified item held in the queue between front and back
   typedef struct packed {
      logic       is_tick;
      logic [2:0] op;
      logic       shift_load;
      logic [7:0] shift_value;
      logic       sda_in;
   } i2cms_item_type;

   // Queue occupancy as seen by the front
   typedef struct packed {
      logic full;
   } i2cms_qstat_type;

   // Number of line phases in each op
   function automatic logic [4:0] phase_total(input logic [2:0] op);
      logic [4:0] tot;
      unique case (op)
         OP_WRITE: tot = 5'd24;
         OP_READ:  tot = 5'd17;
         default:  tot = 5'd3;
      endcase
      return tot;
   endfunction

endpackage

// File: hdl/i2cms_front.sv
// Front end: takes request beats, decodes the kind and builds queue items.
// Depends on i2cms_pkg.
module i2cms_front
   import i2cms_pkg::*;
(
   input  logic            req_valid,
   output logic            req_stall,
   input  i2cms_req_type   req_data,
   input  i2cms_qstat_type q_stat,
   output logic            push,
   output i2cms_item_type  push_item
);

   always_comb begin
      push_item             = '0;
      push_item.op          = req_data.kind;
      push_item.sda_in      = req_data.sda_in;
      push_item.is_tick     = 1'b0;
      push_item.shift_load  = 1'b0;
      push_item.shift_value = 8'd0;
      unique case (req_data.kind)
         OP_IDLE, OP_TICK2: begin
            push_item.is_tick = 1'b1;
            push_item.op      = OP_IDLE;
         end
         OP_WRITE: begin
            push_item.shift_load  = 1'b1;
            push_item.shift_value = req_data.tx_byte;
         end
         OP_READ: begin
            push_item.shift_load = 1'b1;
         end
         OP_MACK: begin
            push_item.shift_load  = 1'b1;
            push_item.shift_value = {7'd0, req_data.master_nack};
         end
         default: begin
         end
      endcase
   end

   assign req_stall = q_stat.full;
   assign push      = req_valid & ~q_stat.full;

endmodule

// File: hdl/i2cms_queue.sv
// Two-entry queue of classified items between front and back.
// Depends on i2cms_pkg.
module i2cms_queue
   import i2cms_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  i2cms_item_type  push_item,
   input  logic            pop,
   output logic            head_valid,
   output i2cms_item_type  head_item,
   output i2cms_qstat_type q_stat
);

   i2cms_item_type       entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   localparam logic [Q_PTR_W-1:0] PTR_LAST = Q_PTR_W'(Q_DEPTH - 1);
   localparam logic [Q_CNT_W-1:0] CNT_FULL = Q_CNT_W'(Q_DEPTH);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_valid   = (count_ff != '0);
   assign head_item    = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CNT_FULL);

endmodule

// File: hdl/i2cms_back.sv
// Back end: phase sequencer, line levels, shift register and result register.
// Depends on i2cms_pkg.
module i2cms_back
   import i2cms_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_wr_en,
   input  logic [15:0]    csr_wr_data,
   input  logic           head_valid,
   input  i2cms_item_type head_item,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output i2cms_rsp_type  rsp_data
);

   logic [15:0]   phase_ticks_ff;
   logic [2:0]    op_ff, op_in;
   logic [4:0]    phase_ff, phase_in;
   logic [15:0]   tick_ff, tick_in;
   logic [7:0]    shift_ff, shift_in;
   logic          scl_ff, scl_in;
   logic          sda_ff, sda_in;
   logic [7:0]    rx_ff, rx_in;
   logic          ack_ff, ack_in;
   logic          rsp_valid_ff;
   i2cms_rsp_type rsp_ff, rsp_in;

   // Line levels after entering phase p of op; {scl, sda}
   function automatic logic [1:0] apply_phase(input logic [2:0] op, input logic [4:0] p,
                                              input logic [7:0] sh, input logic scl,
                                              input logic sda);
      logic [8:0] prod;
      logic [2:0] grp;
      logic [4:0] rem;
      logic       s_c;
      logic       s_d;
      s_c  = scl;
      s_d  = sda;
      prod = {1'b0, p, 3'b000} + {3'b000, p, 1'b0} + {4'b0000, p};  // p*11
      grp  = prod[7:5];                                             // p/3 for p < 24
      rem  = p - ({1'b0, grp, 1'b0} + {2'b00, grp});
      unique case (op)
         OP_START: begin
            if (p == 5'd0) begin
               s_c = 1'b1;
               s_d = 1'b1;
            end else if (p == 5'd1) begin
               s_d = 1'b0;
            end else begin
               s_c = 1'b0;
            end
         end
         OP_STOP: begin
            if (p == 5'd0) begin
               s_c = 1'b0;
               s_d = 1'b0;
            end else if (p == 5'd1) begin
               s_c = 1'b1;
            end else begin
               s_d = 1'b1;
            end
         end
         OP_WRITE: begin
            if (rem[1:0] == 2'd0) begin
               s_c = 1'b0;
               s_d = sh[3'd7 - grp];
            end else begin
               s_c = (rem[1:0] == 2'd1);
            end
         end
         OP_READ: begin
            if (p == 5'd0) begin
               s_c = 1'b0;
               s_d = 1'b1;
            end else begin
               s_c = p[0];
            end
         end
         OP_SACK: begin
            if (p == 5'd0) begin
               s_c = 1'b0;
               s_d = 1'b1;
            end else begin
               s_c = (p == 5'd1);
            end
         end
         OP_MACK: begin
            if (p == 5'd0) begin
               s_c = 1'b0;
               s_d = sh[0];
            end else begin
               s_c = (p == 5'd1);
            end
         end
         default: begin
         end
      endcase
      return {s_c, s_d};
   endfunction

   logic [15:0] len;
   logic [15:0] tick_inc;
   logic [4:0]  phase_next;
   logic        done;
   logic        rej;

   assign pop = head_valid & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      op_in      = op_ff;
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      shift_in   = shift_ff;
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      rx_in      = rx_ff;
      ack_in     = ack_ff;
      done       = 1'b0;
      rej        = 1'b0;
      len        = (phase_ticks_ff == 16'd0) ? 16'd1 : phase_ticks_ff;
      tick_inc   = tick_ff + 16'd1;
      phase_next = phase_ff + 5'd1;
      if (head_item.is_tick) begin
         if (op_ff != OP_IDLE) begin
            if (tick_inc >= len) begin
               // end of phase: sample on the tick closing an SCL-high phase
               if (op_ff == OP_READ && phase_ff[0]) begin
                  shift_in = {shift_ff[6:0], head_item.sda_in};
               end else if (op_ff == OP_SACK && phase_ff == 5'd1) begin
                  ack_in = head_item.sda_in;
               end
               tick_in = 16'd0;
               if (phase_next >= phase_total(op_ff)) begin
                  if (op_ff == OP_READ) begin
                     rx_in = shift_in;
                  end
                  op_in    = OP_IDLE;
                  phase_in = 5'd0;
                  done     = 1'b1;
               end else begin
                  phase_in         = phase_next;
                  {scl_in, sda_in} = apply_phase(op_ff, phase_next, shift_in, scl_ff, sda_ff);
               end
            end else begin
               tick_in = tick_inc;
            end
         end
      end else if (op_ff != OP_IDLE) begin
         rej = 1'b1;
      end else begin
         op_in    = head_item.op;
         phase_in = 5'd0;
         tick_in  = 16'd0;
         if (head_item.shift_load) begin
            shift_in = head_item.shift_value;
         end
         {scl_in, sda_in} = apply_phase(head_item.op, 5'd0, shift_in, scl_ff, sda_ff);
      end

      rsp_in.scl_level  = scl_in;
      rsp_in.sda_level  = sda_in;
      rsp_in.busy_res   = (op_in != OP_IDLE);
      rsp_in.done_res   = done;
      rsp_in.rx_byte    = rx_in;
      rsp_in.slave_nack = ack_in;
      rsp_in.rejected   = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RST;
      end else if (csr_wr_en) begin
         phase_ticks_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff        <= OP_IDLE;
         phase_ff     <= 5'd0;
         tick_ff      <= 16'd0;
         shift_ff     <= 8'd0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         rx_ff        <= 8'd0;
         ack_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            op_ff    <= op_in;
            phase_ff <= phase_in;
            tick_ff  <= tick_in;
            shift_ff <= shift_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
            rx_ff    <= rx_in;
            ack_ff   <= ack_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: hdl/i2c_master_bit_sequencer.sv
// Top level of the I2C master line sequencer: front, queue and back.
// Depends on i2cms_pkg, i2cms_front, i2cms_queue, i2cms_back.
//
// Usage
//  - req_*: one beat per command (start, stop, write byte, read byte, slave
//    ack, master ack) or tick; a tick carries the sampled SDA level.
//    Accepted when req_valid is high and req_stall is low.
//  - rsp_*: exactly one beat per request beat, in order, with the SCL/SDA
//    output levels and status after that beat. Taken when rsp_stall is low.
//  - csr_*: csr_wr_en writes csr_wr_data into phase_ticks (ticks per line
//    phase, 0 acts as 1). Write only while idle.
//  - The response is registered on the edge that pops the item from the queue;
//    an accepted beat is first written into the queue, then popped into the
//    response register, and is taken from there when rsp_stall is low.
//  - Throughput: one beat per clock while rsp_stall is low; the back end retires
//    one queued item per cycle into its output register while that is free.
//  - A two-entry queue parts the sides: while rsp_stall is high the front
//    still fills the queue, and req_stall rises once it is full.
//  - Reset (synchronous, active high) empties the queue and output register,
//    releases both lines, clears status and sets phase_ticks to 5.
module i2c_master_bit_sequencer
   import i2cms_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [15:0]   csr_wr_data,
   input  logic          req_valid,
   output logic          req_stall,
   input  i2cms_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output i2cms_rsp_type rsp_data
);

   i2cms_qstat_type q_stat;
   logic            push;
   i2cms_item_type  push_item;
   logic            pop;
   logic            head_valid;
   i2cms_item_type  head_item;

   // decode and admission
   i2cms_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .push_item (push_item)
   );

   // decoupling queue
   i2cms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .q_stat     (q_stat)
   );

   // sequencer and response register
   i2cms_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head_valid  (head_valid),
      .head_item   (head_item),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// File: sim/tb_i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps
// Self-checking testbench for i2c_master_bit_sequencer: directed table, then random
// command/tick sequences over several phase lengths. Depends on i2cms_pkg and the RTL.
module tb_i2c_master_bit_sequencer;
   import i2cms_pkg::*;

   // settle modes for the directed table: tick the running sequence out or not
   localparam int SETTLE_NONE = -1;
   localparam int SDA_LOW     = 0;
   localparam int SDA_HIGH    = 1;
   localparam int SDA_RANDOM  = 2;

   // cycles with no beat on either side before the run is declared hung
   localparam int HANG_LIMIT = 2000;

   // phase_ticks per random phase: zero length, short ones, then the maximum last
   localparam int N_PHASES = 7;
   localparam logic [15:0] PHASE_LEN_PLAN [N_PHASES] =
      '{16'd0, 16'd1, 16'd3, 16'd2, 16'd7, 16'd1, 16'hFFFF};

   typedef struct {
      i2cms_req_type beat;
      bit            typed;   // want holds a hand-written result
      i2cms_rsp_type want;
      int            settle;  // tick mode used to run the sequence out
   } dir_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_wr_en = 1'b0;
   logic [15:0]   csr_wr_data = '0;
   logic          req_valid = 1'b0;
   logic          req_stall;
   i2cms_req_type req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   i2cms_rsp_type rsp_data;

   // line status words still owed by the block, oldest first
   i2cms_rsp_type line_status_q[$];
   int            err_cnt = 0;
   int            dead_cycles = 0;
   bit            no_gaps = 1'b0;   // both sides run back to back while set
   int            stall_left = 0;
   dir_row_type   dir_rows[18];

   // Shadow sequencer: same state the block keeps, advanced once per accepted
   // request beat.
   logic [15:0] phase_len_cfg = PHASE_TICKS_RST;
   logic [2:0]  seq_op = OP_IDLE;
   logic [4:0]  seq_phase = '0;
   logic [15:0] seq_ticks = '0;
   logic [7:0]  seq_shift = '0;
   logic        line_scl = 1'b1;
   logic        line_sda = 1'b1;
   logic [7:0]  last_rx = '0;
   logic        last_ack = 1'b0;

   always #2 clock = ~clock;

   i2c_master_bit_sequencer i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   // ---------------------------------------------------------------------
   // Shadow sequencer
   // ---------------------------------------------------------------------

   // Line phases per op: 8 bits x 3 for write, 1 + 8 x 2 for read, else 3
   function automatic int phases_in(input logic [2:0] op);
      int n;
      case (op)
         OP_WRITE: n = 24;
         OP_READ:  n = 17;
         default:  n = 3;
      endcase
      return n;
   endfunction

   // Line levels on entry to phase p of op; unset lines hold their level
   function automatic void set_phase_lines(input logic [2:0] op, input logic [4:0] p);
      int bitpos;
      bitpos = 7 - (int'(p) / 3);
      case (op)
         OP_START: begin
            if (p == 5'd0) begin
               line_scl = 1'b1;
               line_sda = 1'b1;
            end else if (p == 5'd1) begin
               line_sda = 1'b0;
            end else begin
               line_scl = 1'b0;
            end
         end
         OP_STOP: begin
            if (p == 5'd0) begin
               line_scl = 1'b0;
               line_sda = 1'b0;
            end else if (p == 5'd1) begin
               line_scl = 1'b1;
            end else begin
               line_sda = 1'b1;
            end
         end
         OP_WRITE: begin
            // data set up while SCL is low, then SCL high, then low again
            case (int'(p) % 3)
               0: begin
                  line_scl = 1'b0;
                  line_sda = seq_shift[bitpos];
               end
               1:       line_scl = 1'b1;
               default: line_scl = 1'b0;
            endcase
         end
         OP_READ: begin
            if (p == 5'd0) begin
               line_scl = 1'b0;
               line_sda = 1'b1;
            end else begin
               line_scl = p[0];   // odd phases are SCL high
            end
         end
         OP_SACK, OP_MACK: begin
            if (p == 5'd0) begin
               line_scl = 1'b0;
               line_sda = (op == OP_MACK) ? seq_shift[0] : 1'b1;
            end else begin
               line_scl = (p == 5'd1);
            end
         end
         default: ;
      endcase
   endfunction

   // Advance the shadow state by one request beat; returns the line status
   // the block must report for it.
   function automatic i2cms_rsp_type advance_sequencer(input i2cms_req_type beat);
      i2cms_rsp_type st;
      logic [15:0]   len;
      logic          done;
      logic          rej;
      done = 1'b0;
      rej  = 1'b0;
      if (beat.kind == OP_IDLE || beat.kind == OP_TICK2) begin
         if (seq_op != OP_IDLE) begin
            len = (phase_len_cfg == 16'd0) ? 16'd1 : phase_len_cfg;
            seq_ticks = seq_ticks + 16'd1;
            if (seq_ticks >= len) begin
               // SDA is sampled on the tick that closes an SCL-high phase
               if (seq_op == OP_READ && seq_phase[0])
                  seq_shift = {seq_shift[6:0], beat.sda_in};
               else if (seq_op == OP_SACK && seq_phase == 5'd1)
                  last_ack = beat.sda_in;
               seq_phase = seq_phase + 5'd1;
               seq_ticks = '0;
               if (int'(seq_phase) >= phases_in(seq_op)) begin
                  if (seq_op == OP_READ) last_rx = seq_shift;
                  seq_op    = OP_IDLE;
                  seq_phase = '0;
                  done      = 1'b1;
               end else begin
                  set_phase_lines(seq_op, seq_phase);
               end
            end
         end
      end else if (seq_op != OP_IDLE) begin
         rej = 1'b1;
      end else begin
         seq_op    = beat.kind;
         seq_phase = '0;
         seq_ticks = '0;
         case (beat.kind)
            OP_WRITE: seq_shift = beat.tx_byte;
            OP_READ:  seq_shift = '0;
            OP_MACK:  seq_shift = {7'd0, beat.master_nack};
            default:  ;
         endcase
         set_phase_lines(seq_op, 5'd0);
      end
      st.scl_level  = line_scl;
      st.sda_level  = line_sda;
      st.busy_res   = (seq_op != OP_IDLE);
      st.done_res   = done;
      st.rx_byte    = last_rx;
      st.slave_nack = last_ack;
      st.rejected   = rej;
      return st;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Present one beat (after a random gap) and hold it until accepted.
   // Called and returns at a rising edge.
   task automatic send_beat(input i2cms_req_type beat, input bit typed = 1'b0,
                            input i2cms_rsp_type want = '0);
      int            gap;
      i2cms_rsp_type st;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      st = advance_sequencer(beat);
      line_status_q.push_back(typed ? want : st);
   endtask

   // Tick the running sequence to its end; sda_in fixed low/high or random
   task automatic run_to_idle(input int mode);
      i2cms_req_type t;
      while (seq_op != OP_IDLE) begin
         t.kind        = OP_IDLE;
         t.tx_byte     = 8'($urandom);
         t.master_nack = 1'($urandom);
         t.sda_in      = (mode == SDA_RANDOM) ? 1'($urandom) : (mode == SDA_HIGH);
         send_beat(t);
      end
   endtask

   // Mostly well-formed traffic: a command while idle, then ticks until it
   // ends. Noise: stray commands mid-sequence (refused), ticks while idle.
   // Only beats that move the sequencer are counted.
   task automatic random_beat(inout int counted);
      i2cms_req_type b;
      b.tx_byte     = 8'($urandom);
      b.master_nack = 1'($urandom);
      b.sda_in      = 1'($urandom);
      if (seq_op != OP_IDLE) begin
         if ($urandom_range(0, 11) == 0) begin
            b.kind = 3'($urandom_range(OP_START, OP_MACK));
         end else begin
            b.kind = ($urandom_range(0, 7) == 0) ? OP_TICK2 : OP_IDLE;
            counted++;
         end
      end else begin
         if ($urandom_range(0, 6) == 0) begin
            b.kind = ($urandom_range(0, 1) == 0) ? OP_TICK2 : OP_IDLE;
         end else begin
            b.kind = 3'($urandom_range(OP_START, OP_MACK));
            counted++;
         end
      end
      send_beat(b);
   endtask

   function automatic dir_row_type mk_row(input logic [2:0] kind, input logic [7:0] tx,
                                          input logic mn, input logic sda,
                                          input int settle);
      dir_row_type r;
      r.beat.kind        = kind;
      r.beat.tx_byte     = tx;
      r.beat.master_nack = mn;
      r.beat.sda_in      = sda;
      r.typed            = 1'b0;
      r.want             = '0;
      r.settle           = settle;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Response side: random stall after each taken beat, in-order compare
   // ---------------------------------------------------------------------

   task automatic cmp_field(input string name, input logic [7:0] want,
                            input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         err_cnt++;
      end
   endtask

   task automatic check_line_status(input i2cms_rsp_type got);
      i2cms_rsp_type want;
      if (line_status_q.size() == 0) begin
         $error("response beat with nothing outstanding: %0h", got);
         err_cnt++;
      end else begin
         want = line_status_q.pop_front();
         cmp_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
         cmp_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
         cmp_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
         cmp_field("done_res", 8'(want.done_res), 8'(got.done_res));
         cmp_field("rx_byte", want.rx_byte, got.rx_byte);
         cmp_field("slave_nack", 8'(want.slave_nack), 8'(got.slave_nack));
         cmp_field("rejected", 8'(want.rejected), 8'(got.rejected));
      end
   endtask

   // stall_left counts the stall cycles still owed after the last taken beat
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_line_status(rsp_data);
            stall_left = no_gaps ? 0 : $urandom_range(0, 5);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   // ---------------------------------------------------------------------
   // Hang detection: any beat on either side restarts the count
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         dead_cycles <= 0;
      else
         dead_cycles <= dead_cycles + 1;
   end

   initial begin
      do @(posedge clock); while (dead_cycles < HANG_LIMIT);
      $display("tb_i2c_master_bit_sequencer: errors");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int            ph;
      int            counted;
      i2cms_rsp_type w_idle;
      i2cms_rsp_type w_start;
      i2cms_rsp_type w_reject;

      // released bus after reset; start enters phase 0 with both lines high
      w_idle            = '0;
      w_idle.scl_level  = 1'b1;
      w_idle.sda_level  = 1'b1;
      w_start           = w_idle;
      w_start.busy_res  = 1'b1;
      w_reject          = w_start;
      w_reject.rejected = 1'b1;

      // Directed table, run at the reset phase length of 5 ticks
      dir_rows[0]  = mk_row(OP_IDLE,  8'h00, 1'b0, 1'b0, SETTLE_NONE);  // tick while idle
      dir_rows[1]  = mk_row(OP_TICK2, 8'hFF, 1'b1, 1'b1, SETTLE_NONE);  // unused kind = tick
      dir_rows[2]  = mk_row(OP_START, 8'h00, 1'b0, 1'b0, SETTLE_NONE);
      dir_rows[3]  = mk_row(OP_STOP,  8'hFF, 1'b1, 1'b1, SETTLE_NONE);  // refused, busy
      dir_rows[4]  = mk_row(OP_IDLE,  8'h00, 1'b0, 1'b1, SDA_RANDOM);
      dir_rows[5]  = mk_row(OP_WRITE, 8'h00, 1'b1, 1'b1, SDA_RANDOM);
      dir_rows[6]  = mk_row(OP_WRITE, 8'hFF, 1'b0, 1'b0, SDA_RANDOM);
      dir_rows[7]  = mk_row(OP_READ,  8'h00, 1'b0, 1'b0, SDA_HIGH);     // reads FF
      dir_rows[8]  = mk_row(OP_READ,  8'hFF, 1'b1, 1'b1, SDA_LOW);      // reads 00
      dir_rows[9]  = mk_row(OP_SACK,  8'h00, 1'b0, 1'b0, SDA_HIGH);     // slave nack
      dir_rows[10] = mk_row(OP_SACK,  8'hFF, 1'b1, 1'b1, SDA_LOW);      // slave ack
      dir_rows[11] = mk_row(OP_MACK,  8'h00, 1'b0, 1'b0, SDA_RANDOM);
      dir_rows[12] = mk_row(OP_MACK,  8'hFF, 1'b1, 1'b1, SDA_RANDOM);
      dir_rows[13] = mk_row(OP_STOP,  8'h00, 1'b0, 1'b0, SDA_RANDOM);
      dir_rows[14] = mk_row(OP_IDLE,  8'hFF, 1'b1, 1'b1, SETTLE_NONE);  // lines hold after stop
      dir_rows[15] = mk_row(OP_WRITE, 8'h5A, 1'b0, 1'b0, SETTLE_NONE);
      dir_rows[16] = mk_row(OP_READ,  8'hA5, 1'b1, 1'b1, SETTLE_NONE);  // refused mid-write
      dir_rows[17] = mk_row(OP_TICK2, 8'h00, 1'b0, 1'b0, SDA_RANDOM);
      dir_rows[0].typed = 1'b1;
      dir_rows[0].want  = w_idle;
      dir_rows[1].typed = 1'b1;
      dir_rows[1].want  = w_idle;
      dir_rows[2].typed = 1'b1;
      dir_rows[2].want  = w_start;
      dir_rows[3].typed = 1'b1;
      dir_rows[3].want  = w_reject;

      // synchronous reset, released before the directed table
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
         if (dir_rows[i].settle != SETTLE_NONE) run_to_idle(dir_rows[i].settle);
      end

      // Random phases. phase_ticks only changes with the sequencer idle and
      // every response in; the last phase (maximum length) never finishes its
      // first sequence, so it stays short.
      for (ph = 0; ph < N_PHASES; ph++) begin
         run_to_idle(SDA_RANDOM);
         req_valid <= 1'b0;
         while (line_status_q.size() != 0) @(posedge clock);
         repeat (4) @(posedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= PHASE_LEN_PLAN[ph];
         @(posedge clock);
         csr_wr_en     <= 1'b0;
         phase_len_cfg  = PHASE_LEN_PLAN[ph];
         no_gaps        = (ph % 3 == 1);
         counted        = 0;
         while (counted < ((ph == N_PHASES - 1) ? 10 : 20)) random_beat(counted);
      end

      // drain, then wait for any stray beat to show up
      req_valid <= 1'b0;
      while (line_status_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (err_cnt == 0)
         $display("tb_i2c_master_bit_sequencer: clean");
      else
         $display("tb_i2c_master_bit_sequencer: errors");
      $finish;
   end

endmodule

// File: i2c_master_bit_sequencer.f
hdl/i2cms_pkg.sv
hdl/i2cms_front.sv
hdl/i2cms_queue.sv
hdl/i2cms_back.sv
hdl/i2c_master_bit_sequencer.sv
sim/tb_i2c_master_bit_sequencer.sv
